// ===== sv/assert_macros.svh =====
// Assertion macros for modules that check themselves; the top level uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ccdik_pkg.sv =====
// Types, constants and the arctangent table of the inverse kinematics block.
package ccdik_pkg;

    localparam int MAX_LINKS = 5;
    localparam int STEP_W    = 5;
    localparam int XY_W      = 44;
    localparam int Z_W       = 34;

    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    localparam logic [2:0] REG_LEN_A  = 3'd0;
    localparam logic [2:0] REG_BASE_X = 3'd5;
    localparam logic [2:0] REG_BASE_Y = 3'd6;

    localparam logic [23:0] LEN_RESET [MAX_LINKS] =
        '{24'd262144, 24'd196608, 24'd393216, 24'd262144, 24'd131072};
    localparam logic [15:0] ANGLE_RESET [MAX_LINKS] =
        '{16'd0, 16'd58982, 16'd54613, 16'd49152, 16'd16384};

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_cmd_t;

    function automatic logic [31:0] atan_lookup(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ccd_inverse_kinematics_sweep.sv =====
// Top level: planar chain inverse kinematics, one coordinate descent sweep per target.
//
// Usage. A target point arrives as one request on the s_axis channel (goal_x in
// the low 32 bits of tdata, goal_y above). The block then visits the joints from
// the last to the first. For each joint it rebuilds the chain from the base with
// CORDIC rotations, measures the angle between the end vector and the target
// vector with two CORDIC vectoring passes, and turns the joint by that angle.
// After a last forward pass it sends LINK_COUNT requests on m_axis, base link
// first, each with the link number, the joint angle and the link's far end; tlast
// marks the last link. Link lengths and the base position are written on the cfg
// channel, which is always ready; write it only while the block is idle.
// The single shared CORDIC unit runs every rotation and vectoring pass, one at a
// time, and sets the pace. A forward pass rotates each link in turn; a joint visit
// adds two vectoring passes, or none when a vector is zero. Each target takes one
// forward pass per joint visit plus a last one before the results are sent.
// The block accepts no target until the last result has been taken. A stalled
// receiver simply holds the current result. Reset restores the default lengths,
// the base at the origin and the initial joint angles.
module ccd_inverse_kinematics_sweep #(
    parameter int LINK_COUNT   = 5,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // goal_x[31:0], goal_y[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // link_number[2:0], joint_angle[18:3], tip_x[50:19], tip_y[82:51], zero fill
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast,   // final_link
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    `include "assert_macros.svh"

    localparam int KW = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(LINK_COUNT - 1);
    localparam int XW = ccdik_pkg::XY_W;
    localparam int ZW = ccdik_pkg::Z_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FK_INIT = 4'd1;
    localparam logic [3:0] S_FK_MUL  = 4'd2;
    localparam logic [3:0] S_FK_ROT  = 4'd3;
    localparam logic [3:0] S_FK_WAIT = 4'd4;
    localparam logic [3:0] S_VEC_SEL = 4'd5;
    localparam logic [3:0] S_VEC_CHK = 4'd6;
    localparam logic [3:0] S_VT_GO   = 4'd7;
    localparam logic [3:0] S_VT_WAIT = 4'd8;
    localparam logic [3:0] S_VO_GO   = 4'd9;
    localparam logic [3:0] S_VO_WAIT = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    logic [3:0]         state_reg, state_next;
    logic [KW-1:0]      k_reg, k_next, j_reg, j_next;
    logic               final_reg, final_next;
    logic [15:0]        sum_reg;
    logic [55:0]        prod_reg;
    logic signed [31:0] goal_x_reg, goal_y_reg, base_x_reg, base_y_reg;
    logic signed [31:0] cur_x_reg, cur_y_reg;
    logic signed [32:0] ox_reg, oy_reg, tx_reg, ty_reg;
    logic [31:0]        ang_t_reg;
    logic [23:0]        len_reg   [LINK_COUNT];
    logic [15:0]        angle_reg [LINK_COUNT];
    logic signed [31:0] tip_x_reg [LINK_COUNT];
    logic signed [31:0] tip_y_reg [LINK_COUNT];

    ccdik_pkg::cordic_cmd_t cmd;
    logic signed [XW-1:0]   cx_in, cy_in, cx_out, cy_out;
    logic signed [ZW-1:0]   cz_in, cz_out;
    logic                   c_done;

    ccdik_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .x_in  (cx_in),
        .y_in  (cy_in),
        .z_in  (cz_in),
        .x_out (cx_out),
        .y_out (cy_out),
        .z_out (cz_out),
        .done  (c_done)
    );

    // Start of a rotation: fold the absolute link angle into the right half plane.
    logic signed [ZW-1:0] z_abs;
    logic signed [XW-1:0] x_start;
    logic                 fold;
    assign z_abs   = ZW'($signed({sum_reg, 16'h0000}));
    assign x_start = $signed({{(XW - 32){1'b0}}, prod_reg[55:24]});
    assign fold    = (z_abs > $signed(ZW'(34'sd1073741824)))
                  || (z_abs < $signed(-ZW'(34'sd1073741824)));

    // Start of a vectoring pass: scale by 256 and move into the right half plane.
    logic signed [32:0]   vx, vy;
    logic signed [XW-1:0] vx_s, vy_s;
    assign vx   = (state_reg == S_VT_GO) ? tx_reg : ox_reg;
    assign vy   = (state_reg == S_VT_GO) ? ty_reg : oy_reg;
    assign vx_s = XW'(vx) <<< 8;
    assign vy_s = XW'(vy) <<< 8;

    logic zero_vec;
    assign zero_vec = ((ox_reg == 33'sd0) && (oy_reg == 33'sd0))
                   || ((tx_reg == 33'sd0) && (ty_reg == 33'sd0));

    always_comb
    begin
        cmd   = '0;
        cx_in = x_start;
        cy_in = '0;
        cz_in = z_abs;
        if (state_reg == S_FK_ROT)
        begin
            cmd.start  = 1'b1;
            cmd.rotate = 1'b1;
            if (fold)
            begin
                cx_in = -x_start;
                cz_in = z_abs[ZW-1] ? z_abs + ZW'(34'sd2147483648)
                                    : z_abs - ZW'(34'sd2147483648);
            end
        end
        else if ((state_reg == S_VT_GO && !zero_vec) || state_reg == S_VO_GO)
        begin
            cmd.start = 1'b1;
            cx_in     = vx_s[XW-1] ? -vx_s : vx_s;
            cy_in     = vx_s[XW-1] ? -vy_s : vy_s;
            cz_in     = vx_s[XW-1] ? ZW'(34'sd2147483648) : '0;
        end
    end

    // Tip update: rounded offset added to the previous tip, saturated.
    logic signed [XW-1:0] rx, ry;
    logic signed [36:0]   nx_w, ny_w;
    logic signed [31:0]   nx, ny;
    assign rx   = (cx_out + XW'(128)) >>> 8;
    assign ry   = (cy_out + XW'(128)) >>> 8;
    assign nx_w = 37'(cur_x_reg) + 37'(rx);
    assign ny_w = 37'(cur_y_reg) + 37'(ry);

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -37'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    assign nx = sat32(nx_w);
    assign ny = sat32(ny_w);

    // Joint position for the visited joint: the base for joint 0.
    logic signed [31:0] pj_x, pj_y;
    assign pj_x = (k_reg == '0) ? base_x_reg : tip_x_reg[KW'(k_reg - 1'b1)];
    assign pj_y = (k_reg == '0) ? base_y_reg : tip_y_reg[KW'(k_reg - 1'b1)];

    logic [31:0] delta;
    logic [31:0] delta_r;
    assign delta   = ang_t_reg - cz_out[31:0];
    assign delta_r = delta + 32'h0000_8000;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        final_next = final_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    j_next     = K_LAST;
                    final_next = 1'b0;
                    state_next = S_FK_INIT;
                end
            end
            S_FK_INIT:
            begin
                k_next     = '0;
                state_next = S_FK_MUL;
            end
            S_FK_MUL:  state_next = S_FK_ROT;
            S_FK_ROT:  state_next = S_FK_WAIT;
            S_FK_WAIT:
            begin
                if (c_done)
                begin
                    if (k_reg == K_LAST)
                    begin
                        state_next = final_reg ? S_OUT : S_VEC_SEL;
                        k_next     = '0;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_FK_MUL;
                    end
                end
            end
            S_VEC_SEL:
            begin
                k_next     = j_reg;
                state_next = S_VEC_CHK;
            end
            S_VEC_CHK: state_next = S_VT_GO;
            S_VT_GO:
            begin
                if (zero_vec)
                begin
                    state_next = S_FK_INIT;
                    if (j_reg == '0)
                        final_next = 1'b1;
                    else
                        j_next = j_reg - 1'b1;
                end
                else
                begin
                    state_next = S_VT_WAIT;
                end
            end
            S_VT_WAIT:
            begin
                if (c_done)
                    state_next = S_VO_GO;
            end
            S_VO_GO:   state_next = S_VO_WAIT;
            S_VO_WAIT:
            begin
                if (c_done)
                begin
                    state_next = S_FK_INIT;
                    if (j_reg == '0)
                        final_next = 1'b1;
                    else
                        j_next = j_reg - 1'b1;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (k_reg == K_LAST)
                        state_next = S_IDLE;
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            j_reg      <= '0;
            final_reg  <= 1'b0;
            base_x_reg <= '0;
            base_y_reg <= '0;
            for (int i = 0; i < LINK_COUNT; i++)
            begin
                len_reg[i]   <= ccdik_pkg::LEN_RESET[i];
                angle_reg[i] <= ccdik_pkg::ANGLE_RESET[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            final_reg <= final_next;
            if (cfg_valid)
            begin
                if (cfg_index < 3'(LINK_COUNT))
                    len_reg[cfg_index[KW-1:0]] <= cfg_data[23:0];
                else if (cfg_index == ccdik_pkg::REG_BASE_X)
                    base_x_reg <= cfg_data;
                else if (cfg_index == ccdik_pkg::REG_BASE_Y)
                    base_y_reg <= cfg_data;
            end
            // The visited joint turns by the rounded upper half of the angle step.
            if (state_reg == S_VO_WAIT && c_done)
                angle_reg[k_reg] <= angle_reg[k_reg] + delta_r[31:16];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                goal_x_reg <= s_axis_tdata[31:0];
                goal_y_reg <= s_axis_tdata[63:32];
            end
            S_FK_INIT:
            begin
                sum_reg   <= '0;
                cur_x_reg <= base_x_reg;
                cur_y_reg <= base_y_reg;
            end
            S_FK_MUL:
            begin
                sum_reg  <= sum_reg + angle_reg[k_reg];
                prod_reg <= 56'(len_reg[k_reg]) * 56'(ccdik_pkg::GAIN_Q32);
            end
            S_FK_WAIT:
            begin
                if (c_done)
                begin
                    tip_x_reg[k_reg] <= nx;
                    tip_y_reg[k_reg] <= ny;
                    cur_x_reg        <= nx;
                    cur_y_reg        <= ny;
                end
            end
            S_VEC_CHK:
            begin
                ox_reg <= 33'(tip_x_reg[K_LAST]) - 33'(pj_x);
                oy_reg <= 33'(tip_y_reg[K_LAST]) - 33'(pj_y);
                tx_reg <= 33'(goal_x_reg) - 33'(pj_x);
                ty_reg <= 33'(goal_y_reg) - 33'(pj_y);
            end
            S_VT_WAIT:
            begin
                if (c_done)
                    ang_t_reg <= cz_out[31:0];
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tlast  = (k_reg == K_LAST);
    assign m_axis_tdata  = {5'b0, tip_y_reg[k_reg], tip_x_reg[k_reg], angle_reg[k_reg],
                            3'(k_reg)};

    `ASSERT_NEVER(a_one_side, clk, rst_n, s_axis_tready && m_axis_tvalid,
        "target accepted while results are still pending")
    `ASSERT_NEXT(a_back_idle, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        s_axis_tready, "block did not return to idle after the last result")
    `ASSERT_IMPLIES(a_cordic_done, clk, rst_n, c_done,
        state_reg == S_FK_WAIT || state_reg == S_VT_WAIT || state_reg == S_VO_WAIT,
        "CORDIC finished while the sequencer was not waiting for it")

endmodule

// ===== sv/ccdik_cordic.sv =====
// Shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
module ccdik_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ccdik_pkg::cordic_cmd_t            cmd,
    input  logic signed [ccdik_pkg::XY_W-1:0] x_in,
    input  logic signed [ccdik_pkg::XY_W-1:0] y_in,
    input  logic signed [ccdik_pkg::Z_W-1:0]  z_in,
    output logic signed [ccdik_pkg::XY_W-1:0] x_out,
    output logic signed [ccdik_pkg::XY_W-1:0] y_out,
    output logic signed [ccdik_pkg::Z_W-1:0]  z_out,
    output logic                              done
);

    localparam logic [ccdik_pkg::STEP_W-1:0] LAST_STEP = ccdik_pkg::STEP_W'(CORDIC_STEPS - 1);

    logic signed [ccdik_pkg::XY_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ccdik_pkg::Z_W-1:0]  z_reg, z_next;
    logic [ccdik_pkg::STEP_W-1:0]      step_reg;
    logic                              busy_reg, done_reg, rotate_reg;
    logic signed [ccdik_pkg::XY_W-1:0] xs, ys;
    logic signed [ccdik_pkg::Z_W-1:0]  atan_val;
    logic                              dir;

    assign xs       = x_reg >>> step_reg;
    assign ys       = y_reg >>> step_reg;
    assign atan_val = $signed({2'b00, ccdik_pkg::atan_lookup(step_reg)});
    // Rotation drives the residual angle to zero; vectoring drives y to zero.
    assign dir      = rotate_reg ? !z_reg[ccdik_pkg::Z_W-1] : (y_reg <= 0);

    always_comb
    begin
        if (dir)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
            rotate_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg   <= 1'b1;
                step_reg   <= '0;
                rotate_reg <= cmd.rotate;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign done  = done_reg;

endmodule
